// ----- hdl/box_overlap_pair_finder_unit_macros.svh -----
// assertion macros for the box overlap pair finder
// expects signals named clk and rst_n in the scope where a macro is used
`ifndef BOX_OVERLAP_PAIR_FINDER_UNIT_MACROS_SVH
`define BOX_OVERLAP_PAIR_FINDER_UNIT_MACROS_SVH

`ifndef SYNTH

// property checked only out of reset
`define BOPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define BOPF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BOPF_ASSERT(lbl, prop, msg)
`define BOPF_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- hdl/bopf_pkg.sv -----
// shared types and constants for the box overlap pair finder
// no dependencies
package bopf_pkg;

  localparam int IDX_W      = 5;
  localparam int SLOT_LIMIT = 2 ** IDX_W;
  localparam int COORD_W    = 16;
  localparam int EDGE_W     = COORD_W + 2;

  // operation codes
  localparam logic [1:0] OP_STORE = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic        [COORD_W-1:0] w;
    logic        [COORD_W-1:0] h;
  } box_t;

  // input word
  typedef struct packed {
    logic        [1:0]         operation;
    logic        [IDX_W-1:0]   box_index;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic        [COORD_W-1:0] box_width;
    logic        [COORD_W-1:0] box_height;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] second_index;
    logic             found;
    logic             last;
  } out_word_t;

  // broadcast write/clear to every cell
  typedef struct packed {
    logic             store;
    logic             clear;
    logic [IDX_W-1:0] index;
    box_t             box;
  } cell_wr_t;

  // probe handed from cell to cell during a query
  typedef struct packed {
    logic             act;
    logic [IDX_W-1:0] index;
    logic             have_a;
    box_t             a_box;
  } probe_t;

  // closed intervals [a, a+alen] and [b, b+blen] meet, edges included
  function automatic logic spans_meet(logic signed [COORD_W-1:0] a,
                                      logic [COORD_W-1:0] alen,
                                      logic signed [COORD_W-1:0] b,
                                      logic [COORD_W-1:0] blen);
    logic signed [EDGE_W-1:0] a_lo;
    logic signed [EDGE_W-1:0] a_hi;
    logic signed [EDGE_W-1:0] b_lo;
    logic signed [EDGE_W-1:0] b_hi;
    a_lo = EDGE_W'(a);
    b_lo = EDGE_W'(b);
    a_hi = a_lo + $signed({2'b00, alen});
    b_hi = b_lo + $signed({2'b00, blen});
    return (a_lo <= b_hi) && (a_hi >= b_lo);
  endfunction

endpackage

// ----- hdl/bopf_cell.sv -----
// one slot of the box row: holds a box and its valid bit, checks the passing probe
// depends on bopf_pkg
module bopf_cell #(
  parameter int CELL_ID = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bopf_pkg::cell_wr_t wr,
  input  bopf_pkg::probe_t  probe_in,
  output bopf_pkg::probe_t  probe_out_r,
  output logic              hit
);

  localparam logic [bopf_pkg::IDX_W-1:0] MY_ID = CELL_ID[bopf_pkg::IDX_W-1:0];

  bopf_pkg::box_t   box_r;
  logic             valid_r;
  bopf_pkg::probe_t probe_nxt;

  // slot valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr.clear) begin
      valid_r <= 1'b0;
    end else if (wr.store && (wr.index == MY_ID)) begin
      valid_r <= 1'b1;
    end
  end

  // slot payload
  always_ff @(posedge clk) begin
    if (wr.store && (wr.index == MY_ID)) begin
      box_r <= wr.box;
    end
  end

  // capture the queried box at its own slot, compare at later slots
  always_comb begin
    probe_nxt = probe_in;
    if (probe_in.act && (probe_in.index == MY_ID)) begin
      probe_nxt.have_a = valid_r;
      probe_nxt.a_box  = box_r;
    end
  end

  assign hit = probe_in.act && probe_in.have_a && valid_r &&
               bopf_pkg::spans_meet(probe_in.a_box.x, probe_in.a_box.w, box_r.x, box_r.w) &&
               bopf_pkg::spans_meet(probe_in.a_box.y, probe_in.a_box.h, box_r.y, box_r.h);

  // hand the probe to the next cell, only the active flag is reset
  always_ff @(posedge clk) begin
    probe_out_r.index  <= probe_nxt.index;
    probe_out_r.have_a <= probe_nxt.have_a;
    probe_out_r.a_box  <= probe_nxt.a_box;
    if (!rst_n) begin
      probe_out_r.act <= 1'b0;
    end else begin
      probe_out_r.act <= probe_nxt.act;
    end
  end

endmodule

// ----- hdl/box_overlap_pair_finder_unit.sv -----
// top level of the box overlap pair finder: row of box cells plus result sequencing
// depends on bopf_pkg, bopf_cell and box_overlap_pair_finder_unit_macros.svh
`include "box_overlap_pair_finder_unit_macros.svh"

// Stores up to min(MAX_BOXES, 32) boxes in a row of cells, one box per cell.
// A store or clear word gives no result. A query word sends a probe down the
// row, one cell per cycle: it picks up the queried box at its own slot and tests
// every later valid slot for overlap, so a query keeps busy high until the probe
// has passed the whole cell row; no new word is taken while busy is high. The
// final result shows up in the cycle busy drops, and a new word can be taken at
// the edge that ends that cycle.
// Pairs leave in ascending partner index, at most one per cycle, each held on
// out_data for a single cycle under out_strobe; the receiver cannot stall, so a
// result must be captured when out_strobe is high. The final pair, or the lone
// empty result when nothing overlaps, carries last.
module box_overlap_pair_finder_unit #(
  parameter int MAX_BOXES = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bopf_pkg::in_word_t  in_data,
  output logic                out_strobe,
  output bopf_pkg::out_word_t out_data
);

  localparam int NCELL = (MAX_BOXES < bopf_pkg::SLOT_LIMIT) ? MAX_BOXES : bopf_pkg::SLOT_LIMIT;
  localparam int IDX_W = bopf_pkg::IDX_W;

  logic                 accept;
  logic                 query_accept;
  bopf_pkg::cell_wr_t   wr;
  bopf_pkg::probe_t     probe [NCELL+1];
  logic [NCELL-1:0]     hit_vec;
  logic                 hit_any;
  logic                 sweep_done;

  logic                 busy_r,       busy_nxt;
  logic [IDX_W-1:0]     pos_r,        pos_nxt;
  logic [IDX_W-1:0]     qidx_r,       qidx_nxt;
  logic                 pend_v_r,     pend_v_nxt;
  logic [IDX_W-1:0]     pend_j_r,     pend_j_nxt;
  logic                 out_strobe_r, out_strobe_nxt;
  bopf_pkg::out_word_t  out_data_r,   out_data_nxt;

  assign accept       = start && !busy_r;
  assign query_accept = accept && (in_data.operation == bopf_pkg::OP_QUERY);

  // broadcast write port
  assign wr.store = accept && (in_data.operation == bopf_pkg::OP_STORE);
  assign wr.clear = accept && (in_data.operation == bopf_pkg::OP_CLEAR);
  assign wr.index = in_data.box_index;
  assign wr.box   = '{x: in_data.start_x, y: in_data.start_y,
                      w: in_data.box_width, h: in_data.box_height};

  // probe enters the first cell on a query word
  assign probe[0] = '{act: query_accept, index: in_data.box_index,
                      have_a: 1'b0, a_box: wr.box};

  // row of cells
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    bopf_cell #(
      .CELL_ID(k)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .wr         (wr),
      .probe_in   (probe[k]),
      .probe_out_r(probe[k+1]),
      .hit        (hit_vec[k])
    );
  end

  assign hit_any    = |hit_vec;
  assign sweep_done = probe[NCELL].act;

  // result sequencing: hold the newest pair back until the next one or the end
  always_comb begin
    busy_nxt       = busy_r;
    pos_nxt        = pos_r;
    qidx_nxt       = qidx_r;
    pend_v_nxt     = pend_v_r;
    pend_j_nxt     = pend_j_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    if (query_accept) begin
      busy_nxt   = 1'b1;
      pos_nxt    = IDX_W'(1);
      qidx_nxt   = in_data.box_index;
      pend_v_nxt = 1'b0;
    end else if (busy_r) begin
      pos_nxt = pos_r + IDX_W'(1);
      if (hit_any) begin
        if (pend_v_r) begin
          out_strobe_nxt = 1'b1;
          out_data_nxt   = '{first_index: qidx_r, second_index: pend_j_r,
                             found: 1'b1, last: 1'b0};
        end
        pend_v_nxt = 1'b1;
        pend_j_nxt = pos_r;
      end
      if (sweep_done) begin
        out_strobe_nxt = 1'b1;
        out_data_nxt   = '{first_index: qidx_r,
                           second_index: pend_v_r ? pend_j_r : '0,
                           found: pend_v_r, last: 1'b1};
        busy_nxt       = 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      pend_v_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      pend_v_r     <= pend_v_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    qidx_r     <= qidx_nxt;
    pend_j_r   <= pend_j_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy       = busy_r;
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // checks
  `BOPF_ASSERT(a_empty_is_last, out_strobe && !out_data.found |-> out_data.last, "empty result without last")
  `BOPF_ASSERT(a_pair_order, out_strobe && out_data.found |-> out_data.second_index > out_data.first_index, "partner not above queried slot")
  `BOPF_ASSERT(a_one_hit, $onehot0(hit_vec), "more than one cell hit in a cycle")
  `BOPF_ASSERT(a_query_busy, query_accept |=> busy, "query word did not raise busy")
  `BOPF_ASSERT(a_done_idle, busy && sweep_done |=> !busy && out_strobe, "sweep end without final result")

endmodule
